[design/rtp_pkg.sv]
// Shared types, codes and the tone table of the RTTTL note parser.
package rtp_pkg;

    // One character of the ring-tone string.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_item_t;

    // One parsed note.
    typedef struct packed {
        logic        is_rest;
        logic [11:0] tone_hz;
        logic [18:0] length_ms;
        logic        bad_note;
        logic        song_end;
    } note_item_t;

    // Sequencer around the shared divider.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } state_t;

    // String sections.
    localparam logic [1:0] SEC_NAME     = 2'd0;
    localparam logic [1:0] SEC_DEFAULTS = 2'd1;
    localparam logic [1:0] SEC_NOTES    = 2'd2;

    // Field phases in the default section.
    localparam logic [3:0] PH_NONE     = 4'd0;
    localparam logic [3:0] PH_DLEN     = 4'd1;
    localparam logic [3:0] PH_DLEN2    = 4'd2;
    localparam logic [3:0] PH_DOCT     = 4'd3;
    localparam logic [3:0] PH_BPM      = 4'd4;
    localparam logic [3:0] PH_BPM2     = 4'd5;
    localparam logic [3:0] PH_BPM3     = 4'd6;

    // Field phases in the note section.
    localparam logic [3:0] PH_NLEN1    = 4'd1;
    localparam logic [3:0] PH_NLEN2    = 4'd2;
    localparam logic [3:0] PH_LETTER   = 4'd3;
    localparam logic [3:0] PH_SHARP    = 4'd4;
    localparam logic [3:0] PH_DOT      = 4'd5;
    localparam logic [3:0] PH_OCT      = 4'd6;
    localparam logic [3:0] PH_DOT2     = 4'd7;

    localparam logic [3:0] REST_CODE   = 4'd15;
    localparam logic [3:0] SEMI_B      = 4'd11;

    // Reset values of the defaults.
    localparam logic [6:0] DFLT_LEN    = 7'd4;
    localparam logic [3:0] DFLT_OCT    = 4'd6;
    localparam logic [9:0] DFLT_BPM    = 10'd63;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

    // Frequencies of octaves four to seven, twelve semitones each.
    localparam logic [11:0] TONE_TABLE [48] = '{
        12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
        12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,
        12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
        12'd740,  12'd784,  12'd830,  12'd880,  12'd932,  12'd988,
        12'd1047, 12'd1109, 12'd1175, 12'd1244, 12'd1319, 12'd1397,
        12'd1480, 12'd1568, 12'd1660, 12'd1760, 12'd1865, 12'd1976,
        12'd2093, 12'd2218, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
        12'd2960, 12'd3136, 12'd3320, 12'd3520, 12'd3728, 12'd3951
    };

endpackage

[design/rtp_div.sv]
// Restoring 16-bit divider producing one quotient bit per cycle.
module rtp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] div_reg, div_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;
    logic [16:0] diff;
    logic        fits;

    // Trial subtraction of the divisor from the shifted remainder.
    assign shifted = {rem_reg, quo_reg[15]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[15:0] : shifted[15:0];
            quo_next = {quo_reg[14:0], fits};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/rtttl_note_parser_top.sv]
// Top level of the RTTTL note parser: character parser, sequencer and note register.
//
//  Channel | Direction | Payload      | Handshake
//  --------+-----------+--------------+-------------------------
//  char    | in        | char_item_t  | char_valid / char_stall
//  note    | out       | note_item_t  | note_valid / note_stall
//
// A character that finishes no note is taken at once while the sequencer is idle.
// A character that finishes a note keeps char_stall high while the note passes
// twice through the shared bit-serial divider, each pass until its done flag is
// read, tempo first and then note length, and then through the hand-over, which
// a stalled output can hold. A zero tempo or length skips the divider. Reset is
// asynchronous and active low and needs no clearing pass.
// A stalled note waits in the output register while the next characters are
// still taken; a second note then waits in the sequencer until it is free.
module rtttl_note_parser_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  rtp_pkg::char_item_t char_item,
    output logic                note_valid,
    input  logic                note_stall,
    output rtp_pkg::note_item_t note_item
);
    import rtp_pkg::*;

    // Parser state.
    logic [1:0] section_reg, section_next;
    logic [3:0] phase_reg, phase_next;
    logic [6:0] dflt_len_reg, dflt_len_next;
    logic [3:0] dflt_oct_reg, dflt_oct_next;
    logic [9:0] bpm_reg, bpm_next;
    logic [6:0] note_len_reg, note_len_next;
    logic [3:0] semi_reg, semi_next;
    logic [3:0] note_oct_reg, note_oct_next;
    logic       dot_reg, dot_next;

    // Values after the character, before a note is taken out.
    logic [1:0] sec_c;
    logic [3:0] ph_c;
    logic [6:0] dl_c;
    logic [3:0] do_c;
    logic [9:0] bpm_c;
    logic [6:0] nl_c;
    logic [3:0] semi_c;
    logic [3:0] no_c;
    logic       dot_c;
    logic       comma_emit;
    logic       emit;
    logic       handled;

    // Note under computation.
    state_t      state_reg, state_next;
    logic [6:0]  sn_len_reg, sn_len_next;
    logic [3:0]  sn_semi_reg, sn_semi_next;
    logic [3:0]  sn_oct_reg, sn_oct_next;
    logic        sn_dot_reg, sn_dot_next;
    logic        sn_end_reg, sn_end_next;
    logic        sn_zero_reg, sn_zero_next;
    logic [18:0] len_reg, len_next;

    // Output register.
    logic       note_valid_reg, note_valid_next;
    note_item_t note_item_reg, note_item_next;

    // Divider port.
    logic        div_start;
    logic [15:0] div_dividend;
    logic [15:0] div_divisor;
    logic        div_done;
    logic [15:0] div_quotient;

    logic [7:0]  c;
    logic        accept;
    logic        is_digit;
    logic [3:0]  digit;
    logic [3:0]  letter;
    logic [17:0] len4;
    logic        out_rest;
    logic        out_bad;
    logic [5:0]  tone_idx;

    assign c        = char_item.char_code;
    assign accept   = char_valid && !char_stall;
    assign is_digit = c inside {[8'h30:8'h39]};
    assign digit    = c[3:0];

    // Semitone of a note letter; anything else is a rest.
    always_comb
    begin
        case (c)
            "c":     letter = 4'd0;
            "d":     letter = 4'd2;
            "e":     letter = 4'd4;
            "f":     letter = 4'd5;
            "g":     letter = 4'd7;
            "a":     letter = 4'd9;
            "b":     letter = SEMI_B;
            default: letter = REST_CODE;
        endcase
    end

    // Character parser: effect of the character on the parser state.
    always_comb
    begin
        sec_c      = section_reg;
        ph_c       = phase_reg;
        dl_c       = dflt_len_reg;
        do_c       = dflt_oct_reg;
        bpm_c      = bpm_reg;
        nl_c       = note_len_reg;
        semi_c     = semi_reg;
        no_c       = note_oct_reg;
        dot_c      = dot_reg;
        comma_emit = 1'b0;
        handled    = 1'b0;
        case (section_reg)
            SEC_DEFAULTS:
            begin
                case (phase_reg)
                    PH_DLEN, PH_DOCT, PH_BPM:
                    begin
                        if (c == "=" || c == " ")
                        begin
                            handled = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            handled = 1'b1;
                            if (phase_reg == PH_DLEN)
                            begin
                                dl_c = {3'b000, digit};
                                ph_c = PH_DLEN2;
                            end
                            else if (phase_reg == PH_DOCT)
                            begin
                                do_c = digit;
                                ph_c = PH_NONE;
                            end
                            else
                            begin
                                bpm_c = {6'b000000, digit};
                                ph_c  = PH_BPM2;
                            end
                        end
                    end
                    PH_DLEN2:
                    begin
                        if (is_digit)
                        begin
                            handled = 1'b1;
                            dl_c    = 7'(({3'b000, dflt_len_reg} * 10'd10) + {6'b0, digit});
                            ph_c    = PH_NONE;
                        end
                    end
                    PH_BPM2, PH_BPM3:
                    begin
                        if (is_digit)
                        begin
                            handled = 1'b1;
                            bpm_c   = 10'(({4'b0000, bpm_reg} * 14'd10) + {10'b0, digit});
                            ph_c    = (phase_reg == PH_BPM2) ? PH_BPM3 : PH_NONE;
                        end
                    end
                    default:
                    begin
                        handled = 1'b0;
                    end
                endcase
                // Anything not taken as a value is read as a key.
                if (!handled)
                begin
                    ph_c = PH_NONE;
                    if (c == ":")
                    begin
                        sec_c  = SEC_NOTES;
                        nl_c   = dflt_len_reg;
                        no_c   = dflt_oct_reg;
                        semi_c = REST_CODE;
                        dot_c  = 1'b0;
                    end
                    else if (c == "d")
                    begin
                        dl_c = '0;
                        ph_c = PH_DLEN;
                    end
                    else if (c == "o")
                    begin
                        do_c = '0;
                        ph_c = PH_DOCT;
                    end
                    else if (c == "b")
                    begin
                        bpm_c = '0;
                        ph_c  = PH_BPM;
                    end
                end
            end
            SEC_NOTES:
            begin
                if (c == " ")
                begin
                    ph_c = phase_reg;
                end
                else if (phase_reg <= PH_NLEN2)
                begin
                    if (c == ",")
                    begin
                        comma_emit = (phase_reg != PH_NONE);
                    end
                    else if (phase_reg == PH_NONE && is_digit)
                    begin
                        nl_c = {3'b000, digit};
                        ph_c = PH_NLEN1;
                    end
                    else if (phase_reg == PH_NLEN1 && is_digit)
                    begin
                        nl_c = 7'(({3'b000, note_len_reg} * 10'd10) + {6'b0, digit});
                        ph_c = PH_NLEN2;
                    end
                    else
                    begin
                        semi_c = letter;
                        ph_c   = PH_LETTER;
                    end
                end
                else if (c == ",")
                begin
                    comma_emit = 1'b1;
                end
                else if (c == "#" && phase_reg == PH_LETTER)
                begin
                    if (semi_reg < SEMI_B)
                    begin
                        semi_c = semi_reg + 4'd1;
                    end
                    ph_c = PH_SHARP;
                end
                else if (c == "." && (phase_reg == PH_LETTER || phase_reg == PH_SHARP))
                begin
                    dot_c = 1'b1;
                    ph_c  = PH_DOT;
                end
                else if (c == "." && phase_reg == PH_OCT)
                begin
                    dot_c = 1'b1;
                    ph_c  = PH_DOT2;
                end
                else if (is_digit && phase_reg >= PH_LETTER && phase_reg <= PH_DOT)
                begin
                    no_c = digit;
                    ph_c = PH_OCT;
                end
            end
            default:
            begin
                // Song name: skip up to the first colon.
                if (c == ":")
                begin
                    sec_c = SEC_DEFAULTS;
                    ph_c  = PH_NONE;
                end
            end
        endcase
        emit = comma_emit ||
               (char_item.end_of_text && sec_c == SEC_NOTES && ph_c != PH_NONE);
    end

    // Parser state update: reload after a note, full reset at end of text.
    always_comb
    begin
        section_next  = section_reg;
        phase_next    = phase_reg;
        dflt_len_next = dflt_len_reg;
        dflt_oct_next = dflt_oct_reg;
        bpm_next      = bpm_reg;
        note_len_next = note_len_reg;
        semi_next     = semi_reg;
        note_oct_next = note_oct_reg;
        dot_next      = dot_reg;
        if (accept)
        begin
            section_next  = sec_c;
            phase_next    = ph_c;
            dflt_len_next = dl_c;
            dflt_oct_next = do_c;
            bpm_next      = bpm_c;
            note_len_next = nl_c;
            semi_next     = semi_c;
            note_oct_next = no_c;
            dot_next      = dot_c;
            if (emit)
            begin
                note_len_next = dl_c;
                note_oct_next = do_c;
                semi_next     = REST_CODE;
                dot_next      = 1'b0;
                phase_next    = PH_NONE;
            end
            if (char_item.end_of_text)
            begin
                section_next  = SEC_NAME;
                phase_next    = PH_NONE;
                dflt_len_next = DFLT_LEN;
                dflt_oct_next = DFLT_OCT;
                bpm_next      = DFLT_BPM;
                note_len_next = '0;
                semi_next     = REST_CODE;
                note_oct_next = '0;
                dot_next      = 1'b0;
            end
        end
    end

    // Length times four, and times one and a half when dotted.
    assign len4 = {div_quotient, 2'b00};

    // Note fields from the captured note.
    assign out_rest = (sn_semi_reg >= 4'd12);
    assign out_bad  = sn_zero_reg ||
                      (!out_rest && (sn_oct_reg < 4'd4 || sn_oct_reg > 4'd7));
    assign tone_idx = {1'b0, sn_oct_reg[1:0], 3'b000} + {2'b00, sn_oct_reg[1:0], 2'b00} +
                      {2'b00, sn_semi_reg};

    // Sequencer: tempo division, length division, then hand-over; a zero tempo or length goes straight to hand-over.
    always_comb
    begin
        state_next      = state_reg;
        sn_len_next     = sn_len_reg;
        sn_semi_next    = sn_semi_reg;
        sn_oct_next     = sn_oct_reg;
        sn_dot_next     = sn_dot_reg;
        sn_end_next     = sn_end_reg;
        sn_zero_next    = sn_zero_reg;
        len_next        = len_reg;
        note_valid_next = note_valid_reg;
        note_item_next  = note_item_reg;
        div_start       = 1'b0;
        div_dividend    = MS_PER_MINUTE;
        div_divisor     = {6'b000000, bpm_c};

        if (note_valid_reg && !note_stall)
        begin
            note_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && emit)
                begin
                    sn_len_next  = nl_c;
                    sn_semi_next = semi_c;
                    sn_oct_next  = no_c;
                    sn_dot_next  = dot_c;
                    sn_end_next  = char_item.end_of_text;
                    sn_zero_next = (bpm_c == '0) || (nl_c == '0);
                    len_next     = '0;
                    if ((bpm_c == '0) || (nl_c == '0))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV1;
                    end
                end
            end
            ST_DIV1:
            begin
                div_dividend = div_quotient;
                div_divisor  = {9'b000000000, sn_len_reg};
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    if (sn_dot_reg)
                    begin
                        len_next = {1'b0, len4} + {2'b00, len4[17:1]};
                    end
                    else
                    begin
                        len_next = {1'b0, len4};
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!note_valid_reg || !note_stall)
                begin
                    note_valid_next          = 1'b1;
                    note_item_next.is_rest   = out_rest || out_bad;
                    note_item_next.tone_hz   = (out_rest || out_bad) ? 12'd0 :
                                               TONE_TABLE[tone_idx];
                    note_item_next.length_ms = len_reg;
                    note_item_next.bad_note  = out_bad;
                    note_item_next.song_end  = sn_end_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rtp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Control and parser registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            note_valid_reg <= 1'b0;
            section_reg    <= SEC_NAME;
            phase_reg      <= PH_NONE;
            dflt_len_reg   <= DFLT_LEN;
            dflt_oct_reg   <= DFLT_OCT;
            bpm_reg        <= DFLT_BPM;
            note_len_reg   <= '0;
            semi_reg       <= REST_CODE;
            note_oct_reg   <= '0;
            dot_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            note_valid_reg <= note_valid_next;
            section_reg    <= section_next;
            phase_reg      <= phase_next;
            dflt_len_reg   <= dflt_len_next;
            dflt_oct_reg   <= dflt_oct_next;
            bpm_reg        <= bpm_next;
            note_len_reg   <= note_len_next;
            semi_reg       <= semi_next;
            note_oct_reg   <= note_oct_next;
            dot_reg        <= dot_next;
        end
    end

    // Payload registers of the captured note and the output.
    always_ff @(posedge clk)
    begin
        sn_len_reg    <= sn_len_next;
        sn_semi_reg   <= sn_semi_next;
        sn_oct_reg    <= sn_oct_next;
        sn_dot_reg    <= sn_dot_next;
        sn_end_reg    <= sn_end_next;
        sn_zero_reg   <= sn_zero_next;
        len_reg       <= len_next;
        note_item_reg <= note_item_next;
    end

    assign char_stall = (state_reg != ST_IDLE);
    assign note_valid = note_valid_reg;
    assign note_item  = note_item_reg;

endmodule
